FILE: rtl/sine_phase_accumulator_oscillator_assert.svh
// assertion macros for the oscillator checker
`ifndef SINE_PHASE_ACCUMULATOR_OSCILLATOR_ASSERT_SVH
`define SINE_PHASE_ACCUMULATOR_OSCILLATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while in reset
`define SPAO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spao check failed");

// next-cycle implication, sampled on clk, quiet while in reset
`define SPAO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spao check failed");

`endif

FILE: rtl/spao_pkg.sv
// shared types, constants and sine table for the phase accumulator oscillator
package spao_pkg;

    // phase and table geometry
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 8;
    localparam int QUARTER_BITS    = PHASE_BITS - 2;
    localparam int FRAC_BITS       = QUARTER_BITS - TABLE_ADDR_BITS;
    localparam int IDX_W           = TABLE_ADDR_BITS + 1;
    localparam int TBL_LEN         = (1 << TABLE_ADDR_BITS) + 1;

    // field widths
    localparam int FREQ_W   = 24;
    localparam int RATE_W   = 39;
    localparam int SAMPLE_W = 16;
    localparam int QSIN_W   = 17;
    localparam int MIX_W    = QSIN_W + 1;

    // rate_recip is split in two halves for the shared multiplier
    localparam int RATE_LO_W = 20;
    localparam int MUL_A_W   = FREQ_W;
    localparam int MUL_B_W   = (FRAC_BITS > RATE_LO_W) ? FRAC_BITS : RATE_LO_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int PROD_W    = FREQ_W + RATE_W;

    // Q8 frequency times 2^48 scaled reciprocal gives a Q56 cycle count
    localparam int INC_SHIFT = 56 - PHASE_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RATE_W;

    // table generation
    localparam int TAYLOR_TERMS = 20;

    typedef logic [FREQ_W-1:0]       freq_t;
    typedef logic [RATE_W-1:0]       rate_t;
    typedef logic [PHASE_BITS-1:0]   phase_t;
    typedef logic [QUARTER_BITS:0]   quarter_t;
    typedef logic [FRAC_BITS-1:0]    frac_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [QSIN_W-1:0]       qsin_t;
    typedef logic [MIX_W-1:0]        mix_t;
    typedef logic [SAMPLE_W-1:0]     sample_t;
    typedef logic [MUL_A_W-1:0]      mul_a_t;
    typedef logic [MUL_B_W-1:0]      mul_b_t;
    typedef logic [MUL_P_W-1:0]      mul_p_t;
    typedef logic [PROD_W-1:0]       prod_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
    typedef logic [TBL_LEN-1:0][QSIN_W-1:0] qsin_tbl_t;

    // register indexes
    localparam cfg_idx_t CFG_START_FREQ = 2'd0;
    localparam cfg_idx_t CFG_RATE_RECIP = 2'd1;

    localparam rate_t    RATE_RESET   = 39'd5864062015;
    localparam mix_t     ONE_Q16      = 18'h10000;
    localparam quarter_t QUARTER_ONE  = {1'b1, {QUARTER_BITS{1'b0}}};
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // divisors (n+1)(n+2) of the odd Taylor terms
    localparam logic [10:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        11'd6,   11'd20,  11'd42,  11'd72,   11'd110,  11'd156,  11'd210,
        11'd272, 11'd342, 11'd420, 11'd506,  11'd600,  11'd702,  11'd812,
        11'd930, 11'd1056, 11'd1190, 11'd1332, 11'd1482, 11'd1640
    };

    // controller state
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_PHASE,
        ST_LOOKUP,
        ST_INTERP,
        ST_MIX
    } spao_state_t;

    // datapath commands, one step per bit
    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic acc;
        logic phase_step;
        logic lookup;
        logic interp;
        logic mix;
    } spao_cmd_t;

    // sin of a Q30 angle in [0, pi/2], Q16 result, Taylor series
    function automatic qsin_t sin_q16(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        logic               neg;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        neg  = 1'b1;
        for (int i = 0; i < TAYLOR_TERMS; i++)
        begin
            if (term != 64'd0)
            begin
                term = (term * x2) >> 30;
                term = term / 64'(TAYLOR_DIV[i]);
                if (neg)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
                neg = !neg;
            end
        end
        if (sum < 0)
            sum = 64'sd0;
        // Q30 to Q16, round half up
        r = ($unsigned(sum) + 64'd8192) >> 14;
        if (r > 64'd65536)
            r = 64'd65536;
        return r[QSIN_W-1:0];
    endfunction

    // quarter-wave table, built at elaboration
    function automatic qsin_tbl_t build_qsin();
        qsin_tbl_t tbl;
        for (int k = 0; k < TBL_LEN; k++)
        begin
            tbl[k] = sin_q16((HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS);
        end
        return tbl;
    endfunction

    localparam qsin_tbl_t QSIN = build_qsin();

endpackage

FILE: rtl/sine_phase_accumulator_oscillator.sv
// top level of the direct digital synthesis sine oscillator
// Each accepted item is one sample tick and gives exactly one sample: the phase advances by
// the held frequency times rate_recip, and the output is (sin(2*pi*phase)+1)/2 in Q0.16 from a
// 257-entry quarter-wave table with linear interpolation. The result of an item is written to
// the output register once its steps are through: the shared 24x22 multiplier is used three
// times per item (two partial products for the phase increment, one for the interpolation),
// with the increment sum, phase update, table read and final offset each in a state of their
// own. in_stall stays high while an item is being worked on and the next item is taken in the
// idle cycle that follows, so no new item is taken before the last one is through; a stalled
// output holds the next result back until its register frees up. A write to start_freq loads
// the held frequency at once; writes are taken at any cycle and belong in idle periods.
module sine_phase_accumulator_oscillator (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    freq_valid,
    input  spao_pkg::freq_t         freq_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output spao_pkg::sample_t       sample_out,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  spao_pkg::cfg_idx_t      cfg_index,
    input  spao_pkg::cfg_data_t     cfg_data
);

    spao_pkg::spao_cmd_t cmd;
    logic                cfg_we;

    // register writes never wait
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencer
    spao_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath
    spao_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .freq_valid (freq_valid),
        .freq_in    (freq_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_out (sample_out)
    );

endmodule

FILE: rtl/spao_ctrl.sv
// sequencer for the oscillator: steps the datapath and owns the handshakes
module spao_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output spao_pkg::spao_cmd_t cmd
);

    spao_pkg::spao_state_t state_reg;
    spao_pkg::spao_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // state and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spao_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            spao_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = spao_pkg::ST_MUL_LO;
                end
            end
            spao_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = spao_pkg::ST_MUL_HI;
            end
            spao_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = spao_pkg::ST_ACC;
            end
            spao_pkg::ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = spao_pkg::ST_PHASE;
            end
            spao_pkg::ST_PHASE:
            begin
                cmd.phase_step = 1'b1;
                state_next     = spao_pkg::ST_LOOKUP;
            end
            spao_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = spao_pkg::ST_INTERP;
            end
            spao_pkg::ST_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = spao_pkg::ST_MIX;
            end
            spao_pkg::ST_MIX:
            begin
                // wait for a free output register
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.mix        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = spao_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spao_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != spao_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/spao_dp.sv
// oscillator datapath: registers, shared multiplier, phase, table lookup, output
module spao_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spao_pkg::spao_cmd_t   cmd,
    input  logic                  freq_valid,
    input  spao_pkg::freq_t       freq_in,
    input  logic                  cfg_we,
    input  spao_pkg::cfg_idx_t    cfg_index,
    input  spao_pkg::cfg_data_t   cfg_data,
    output spao_pkg::sample_t     sample_out
);

    // state with reset values
    spao_pkg::freq_t    freq_hold_reg;
    spao_pkg::rate_t    rate_reg;
    spao_pkg::phase_t   phase_reg;

    // working registers
    spao_pkg::mul_p_t   prod_reg;
    spao_pkg::mul_p_t   acc_reg;
    spao_pkg::phase_t   inc_reg;
    spao_pkg::qsin_t    lu_a_reg;
    spao_pkg::qsin_t    lu_d_reg;
    spao_pkg::frac_t    lu_frac_reg;
    logic               lu_neg_reg;
    spao_pkg::sample_t  sample_reg;

    // combinational values
    spao_pkg::mul_a_t   mul_a;
    spao_pkg::mul_b_t   mul_b;
    spao_pkg::mul_p_t   mul_p;
    spao_pkg::prod_t    inc_sum;
    logic [1:0]         quad;
    spao_pkg::quarter_t m_pos;
    spao_pkg::idx_t     idx_a;
    spao_pkg::idx_t     idx_b;
    spao_pkg::qsin_t    tbl_a;
    spao_pkg::qsin_t    tbl_b;
    spao_pkg::qsin_t    tbl_d;
    spao_pkg::mix_t     mag;
    spao_pkg::mix_t     mix_val;
    spao_pkg::sample_t  sample_sat;

    // shared multiplier operand select
    always_comb
    begin
        if (cmd.mul_lo)
        begin
            mul_a = freq_hold_reg;
            mul_b = spao_pkg::mul_b_t'(rate_reg[spao_pkg::RATE_LO_W-1:0]);
        end
        else if (cmd.mul_hi)
        begin
            mul_a = freq_hold_reg;
            mul_b = spao_pkg::mul_b_t'(rate_reg[spao_pkg::RATE_W-1:spao_pkg::RATE_LO_W]);
        end
        else
        begin
            mul_a = spao_pkg::mul_a_t'(lu_d_reg);
            mul_b = spao_pkg::mul_b_t'(lu_frac_reg);
        end
        mul_p = spao_pkg::mul_p_t'(mul_a) * spao_pkg::mul_p_t'(mul_b);
    end

    // phase increment from the two partial products
    assign inc_sum = spao_pkg::prod_t'(acc_reg)
                   + (spao_pkg::prod_t'(prod_reg) << spao_pkg::RATE_LO_W);

    // quadrant, mirrored position and table reads
    always_comb
    begin
        quad  = phase_reg[spao_pkg::PHASE_BITS-1 -: 2];
        m_pos = spao_pkg::quarter_t'(phase_reg[spao_pkg::QUARTER_BITS-1:0]);
        if (quad[0])
            m_pos = spao_pkg::QUARTER_ONE - m_pos;
        idx_a = m_pos[spao_pkg::QUARTER_BITS -: spao_pkg::IDX_W];
        // at the quarter end the last entry stands alone
        idx_b = idx_a[spao_pkg::IDX_W-1] ? idx_a : idx_a + spao_pkg::idx_t'(1);
        tbl_a = spao_pkg::QSIN[idx_a];
        tbl_b = spao_pkg::QSIN[idx_b];
        tbl_d = (tbl_b >= tbl_a) ? (tbl_b - tbl_a) : '0;
    end

    // interpolated magnitude, offset and saturation
    always_comb
    begin
        mag = spao_pkg::mix_t'(lu_a_reg)
            + spao_pkg::mix_t'(prod_reg[spao_pkg::FRAC_BITS +: spao_pkg::QSIN_W]);
        if (lu_neg_reg)
            mix_val = (spao_pkg::ONE_Q16 - mag) >> 1;
        else
            mix_val = (spao_pkg::ONE_Q16 + mag) >> 1;
        sample_sat = mix_val[spao_pkg::SAMPLE_W] ? '1 : mix_val[spao_pkg::SAMPLE_W-1:0];
    end

    // frequency, rate and phase registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_hold_reg <= '0;
            rate_reg      <= spao_pkg::RATE_RESET;
            phase_reg     <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == spao_pkg::CFG_START_FREQ))
                freq_hold_reg <= cfg_data[spao_pkg::FREQ_W-1:0];
            else if (cmd.load && freq_valid)
                freq_hold_reg <= freq_in;
            if (cfg_we && (cfg_index == spao_pkg::CFG_RATE_RECIP))
                rate_reg <= cfg_data[spao_pkg::RATE_W-1:0];
            if (cmd.phase_step)
                phase_reg <= phase_reg + inc_reg;
        end
    end

    // working registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo || cmd.mul_hi || cmd.interp)
            prod_reg <= mul_p;
        if (cmd.mul_hi)
            acc_reg <= prod_reg;
        if (cmd.acc)
            inc_reg <= inc_sum[spao_pkg::INC_SHIFT +: spao_pkg::PHASE_BITS];
        if (cmd.lookup)
        begin
            lu_a_reg    <= tbl_a;
            lu_d_reg    <= tbl_d;
            lu_frac_reg <= m_pos[spao_pkg::FRAC_BITS-1:0];
            lu_neg_reg  <= quad[1];
        end
        if (cmd.mix)
            sample_reg <= sample_sat;
    end

    assign sample_out = sample_reg;

endmodule

FILE: rtl/spao_checker.sv
// port-level checks for the oscillator, bound to the top level
`include "sine_phase_accumulator_oscillator_assert.svh"

module spao_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input spao_pkg::sample_t sample_out
);

    // one item at a time: busy right after an accept
    `SPAO_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a fresh result shows up a fixed latency after its item
    `SPAO_ASSERT_NOW(a_result_latency, $rose(out_valid), $past(in_valid && !in_stall, 8))

    // returning to idle always leaves a result behind
    `SPAO_ASSERT_NOW(a_idle_with_result, $fell(in_stall), out_valid)

    // a stalled item holds
    `SPAO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out))

endmodule

bind sine_phase_accumulator_oscillator spao_checker u_spao_checker (.*);

FILE: tb/sv/sine_phase_accumulator_oscillator_test.sv
// self-checking testbench for the phase accumulator sine oscillator
module sine_phase_accumulator_oscillator_test;

    localparam int                  ITEMS_PER_PHASE = 250;
    localparam int                  RANDOM_PHASES   = 5;
    localparam int                  CHOKE_AT        = 200;
    localparam int                  CHOKE_CYCLES    = 120;
    localparam int                  WATCHDOG_LIMIT  = 2000;
    localparam int                  SETTLE_CYCLES   = 16;
    localparam int                  AUDIO_MAX_Q8    = 20000 * 256;
    localparam spao_pkg::cfg_data_t RATE_TOP        = 39'd281474976711;
    localparam spao_pkg::cfg_data_t RATE_ALL_ONES   = '1;
    localparam spao_pkg::cfg_idx_t  CFG_SPARE_LO    = 2'd2;
    localparam spao_pkg::cfg_idx_t  CFG_SPARE_HI    = 2'd3;

    typedef struct {
        bit              load;
        spao_pkg::freq_t freq;
    } tick_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic                freq_valid = 1'b0;
    spao_pkg::freq_t     freq_in    = '0;
    logic                out_valid;
    logic                out_stall  = 1'b1;
    spao_pkg::sample_t   sample_out;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    spao_pkg::cfg_idx_t  cfg_index  = '0;
    spao_pkg::cfg_data_t cfg_data   = '0;

    // predictor state and configuration
    logic [spao_pkg::QSIN_W-1:0] sine_quarter [spao_pkg::TBL_LEN];
    spao_pkg::freq_t             tone_freq;
    spao_pkg::rate_t             rate_word;
    spao_pkg::phase_t            phase_word;

    tick_t             tick_q [$];
    spao_pkg::sample_t expected_samples [$];
    tick_t             offered;
    spao_pkg::sample_t want;
    int                ticks_waiting = 0;
    int                samples_seen  = 0;
    int                errors        = 0;
    int                send_gap      = 0;
    int                stall_left    = 0;
    int                choke_left    = 0;
    bit                choke_done    = 1'b0;
    bit                idle_on       = 1'b1;
    int                quiet_cycles  = 0;

    sine_phase_accumulator_oscillator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .freq_valid (freq_valid),
        .freq_in    (freq_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #10 clk = ~clk;

    // sine of a q30 angle in [0, pi/2] by taylor series, q16 rounded half up
    function automatic logic [spao_pkg::QSIN_W-1:0] taylor_sin_q16(input logic [63:0] ang);
        logic [63:0] sq;
        logic [63:0] term;
        logic [63:0] rounded;
        longint      acc;
        int          n;
        bit          minus;
        sq    = (ang * ang) >> 30;
        term  = ang;
        acc   = longint'(ang);
        n     = 1;
        minus = 1'b1;
        while (term != 64'd0 && n < 40)
        begin
            term  = (term * sq) >> 30;
            term  = term / 64'((n + 1) * (n + 2));
            n    += 2;
            acc   = minus ? acc - longint'(term) : acc + longint'(term);
            minus = !minus;
        end
        if (acc < 0)
            acc = 0;
        rounded = (64'(acc) + 64'd8192) >> 14;
        if (rounded > 64'd65536)
            rounded = 64'd65536;
        return rounded[spao_pkg::QSIN_W-1:0];
    endfunction

    // one sample tick: load frequency, step the phase, look up the offset sine
    function automatic spao_pkg::sample_t advance_tone(input bit load,
                                                       input spao_pkg::freq_t freq);
        logic [63:0] step_inc;
        logic [63:0] pos;
        logic [63:0] slot;
        logic [63:0] frac;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mag;
        logic [63:0] level;
        logic [1:0]  quad;
        if (load)
            tone_freq = freq;
        step_inc   = (64'(tone_freq) * 64'(rate_word)) >> spao_pkg::INC_SHIFT;
        phase_word = phase_word + step_inc[spao_pkg::PHASE_BITS-1:0];
        quad       = phase_word[spao_pkg::PHASE_BITS-1 -: 2];
        pos        = 64'(phase_word[spao_pkg::QUARTER_BITS-1:0]);
        // odd quadrants run the quarter wave backwards
        if (quad[0])
            pos = (64'd1 << spao_pkg::QUARTER_BITS) - pos;
        slot = pos >> spao_pkg::FRAC_BITS;
        frac = pos & ((64'd1 << spao_pkg::FRAC_BITS) - 64'd1);
        if (slot >= 64'(spao_pkg::TBL_LEN - 1))
            mag = 64'(sine_quarter[spao_pkg::TBL_LEN-1]);
        else
        begin
            lo  = 64'(sine_quarter[slot]);
            hi  = 64'(sine_quarter[slot + 1]);
            mag = lo + ((((hi >= lo) ? hi - lo : 64'd0) * frac) >> spao_pkg::FRAC_BITS);
        end
        level = quad[1] ? (64'd65536 - mag) >> 1 : (64'd65536 + mag) >> 1;
        // the crest saturates
        if (level > 64'd65535)
            level = 64'd65535;
        return level[spao_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic queue_tick(input bit load, input spao_pkg::freq_t freq);
        tick_t t;
        t.load = load;
        t.freq = freq;
        tick_q.push_back(t);
        ticks_waiting++;
    endtask

    // register write, taken into the predictor when accepted
    task automatic write_reg(input spao_pkg::cfg_idx_t idx, input spao_pkg::cfg_data_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == spao_pkg::CFG_START_FREQ)
            tone_freq = value[spao_pkg::FREQ_W-1:0];
        else if (idx == spao_pkg::CFG_RATE_RECIP)
            rate_word = value;
    endtask

    task automatic drain();
        while (ticks_waiting != 0 || expected_samples.size() != 0)
            @(posedge clk);
    endtask

    // item driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_samples.push_back(advance_tone(offered.load, offered.freq));
                ticks_waiting--;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() != 0)
                begin
                    offered    = tick_q.pop_front();
                    in_valid   <= 1'b1;
                    freq_valid <= offered.load;
                    freq_in    <= offered.freq;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 12);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // sample monitor and output stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    $error("sample_out: expected none, actual %0d", sample_out);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                    begin
                        errors++;
                        $error("sample_out: expected %0d, actual %0d", want, sample_out);
                    end
                end
                samples_seen++;
            end
            // one long hold-off so the block backs up into its input
            if (choke_left > 0)
            begin
                choke_left--;
                out_stall <= 1'b1;
            end
            else if (samples_seen == CHOKE_AT && !choke_done)
            begin
                choke_done = 1'b1;
                choke_left = CHOKE_CYCLES;
                out_stall  <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 12);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("sine_phase_accumulator_oscillator_test: FAIL");
                    $finish;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int                  phase_no;
        int                  k;
        spao_pkg::freq_t     f;
        spao_pkg::cfg_data_t rate;
        logic [63:0]         fs;

        for (k = 0; k < spao_pkg::TBL_LEN; k++)
            sine_quarter[k] = taylor_sin_q16((spao_pkg::HALF_PI_Q30 * 64'(k))
                                             >> spao_pkg::TABLE_ADDR_BITS);
        tone_freq  = '0;
        rate_word  = spao_pkg::RATE_RESET;
        phase_word = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // held frequency of zero leaves the phase at rest
        queue_tick(1'b0, spao_pkg::freq_t'($urandom));
        drain();

        // quarter-cycle steps land exactly on crest, zero crossing and trough;
        // high data bits above start_freq and spare indexes are ignored
        write_reg(spao_pkg::CFG_START_FREQ, {15'h7fff, 24'h400000});
        write_reg(spao_pkg::CFG_RATE_RECIP, spao_pkg::cfg_data_t'(64'd1 << 32));
        write_reg(CFG_SPARE_LO, RATE_ALL_ONES);
        write_reg(CFG_SPARE_HI, spao_pkg::cfg_data_t'({$urandom, $urandom}));
        for (k = 0; k < 16; k++)
            queue_tick(1'b0, spao_pkg::freq_t'($urandom));
        queue_tick(1'b1, '1);
        queue_tick(1'b0, '0);
        queue_tick(1'b1, 24'd1);
        queue_tick(1'b1, '0);
        drain();

        // zero rate freezes the phase
        write_reg(spao_pkg::CFG_RATE_RECIP, '0);
        queue_tick(1'b1, '1);
        queue_tick(1'b0, '1);
        drain();

        // widest rate word with the largest frequency
        write_reg(spao_pkg::CFG_RATE_RECIP, RATE_ALL_ONES);
        write_reg(spao_pkg::CFG_START_FREQ, RATE_ALL_ONES);
        queue_tick(1'b0, '0);
        queue_tick(1'b0, spao_pkg::freq_t'($urandom));
        drain();

        // random phases, each under its own configuration
        for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++)
        begin
            case (phase_no)
                1:       rate = 39'd1;
                2:       rate = RATE_TOP;
                3:       rate = spao_pkg::cfg_data_t'({$urandom, $urandom});
                default:
                begin
                    fs   = 64'($urandom_range(8000, 192000));
                    rate = spao_pkg::cfg_data_t'(((64'd1 << 48) + fs / 2) / fs);
                end
            endcase
            case ($urandom_range(0, 3))
                0:       f = '0;
                1:       f = '1;
                2:       f = spao_pkg::freq_t'($urandom);
                default: f = spao_pkg::freq_t'($urandom_range(0, AUDIO_MAX_Q8));
            endcase
            if ($urandom_range(0, 1))
            begin
                write_reg(spao_pkg::CFG_RATE_RECIP, rate);
                write_reg(spao_pkg::CFG_START_FREQ, spao_pkg::cfg_data_t'({$urandom, f}));
            end
            else
            begin
                write_reg(spao_pkg::CFG_START_FREQ, spao_pkg::cfg_data_t'({$urandom, f}));
                write_reg(spao_pkg::CFG_RATE_RECIP, rate);
            end
            // no idling in the closing phase
            if (phase_no == RANDOM_PHASES - 1)
                idle_on <= 1'b0;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    if ($urandom_range(0, 7) == 0)
                        queue_tick(1'b1, spao_pkg::freq_t'($urandom));
                    else
                        queue_tick(1'b1, spao_pkg::freq_t'($urandom_range(0, AUDIO_MAX_Q8)));
                end
                else
                    queue_tick(1'b0, spao_pkg::freq_t'($urandom));
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && expected_samples.size() == 0)
            $display("sine_phase_accumulator_oscillator_test: PASS");
        else
            $display("sine_phase_accumulator_oscillator_test: FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/spao_pkg.sv
rtl/spao_ctrl.sv
rtl/spao_dp.sv
rtl/sine_phase_accumulator_oscillator.sv
rtl/spao_checker.sv
tb/sv/sine_phase_accumulator_oscillator_test.sv
